/* rtl/ppr_pkg.sv */
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants for the ping-pong ring refill control
// Widths, command codes, configuration indexes and transfer payload types.
// ----------------------------------------------------------------------------
package ppr_pkg;

	// Ring size limits in bytes
	localparam int MAX_RING_BYTES = 65536;
	localparam int MIN_RING_BYTES = 16;

	// Field widths
	localparam int RS_W       = 17;	// ring size, byte count
	localparam int HALF_W     = 16;	// half ring
	localparam int EIGHTH_W   = 14;	// eighth of the ring
	localparam int HEAD_W     = 16;
	localparam int TAIL_W     = 15;
	localparam int CURSOR_W   = 16;
	localparam int OFS_W      = 32;	// file offsets
	localparam int DOFS_W     = 16;	// header offset
	localparam int MARK_W     = 33;	// read and write marks
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = 2;	// results per item, up to three

	// Cursor reduction: restoring remainder, a few steps per stage
	localparam int MOD_SHIFTS = CURSOR_W - $clog2(MIN_RING_BYTES);
	localparam int MOD_STEPS  = 4;
	localparam int MOD_STAGES = (MOD_SHIFTS + MOD_STEPS - 1) / MOD_STEPS;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_END    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET = 2'd2;

	// Reset values of the configuration registers
	localparam logic [RS_W-1:0]   RST_RING_SIZE   = 17'h10000;
	localparam logic [OFS_W-1:0]  RST_DATA_END    = 32'd0;
	localparam logic [DOFS_W-1:0] RST_DATA_OFFSET = 16'd44;

	// Command codes
	localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_COPY_HALF  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_COPY_WHOLE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ_AHEAD = 3'd3;
	localparam logic [ACT_W-1:0] ACT_STOP       = 3'd4;

	// Effective configuration (ring size already clamped and made even)
	typedef struct packed {
		logic [RS_W-1:0]   ring;
		logic [OFS_W-1:0]  data_end;
		logic [DOFS_W-1:0] data_offset;
	} cfg_t;

	// Request after the cursor has been reduced modulo the ring size
	typedef struct packed {
		logic                req_type;
		logic                still_playing;
		logic [CURSOR_W-1:0] play;
	} mod_item_t;

	// One command result
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic              half_sel;
		logic [HEAD_W-1:0] blank_head;
		logic [TAIL_W-1:0] blank_tail;
		logic [OFS_W-1:0]  src_offset;
		logic [RS_W-1:0]   byte_count;
		logic              last;
	} rsp_t;

endpackage

/* rtl/ppr_req_if.sv */
// ----------------------------------------------------------------------------
// ppr_req_if: request channel
// Valid/ready channel carrying start and poll requests.
// ----------------------------------------------------------------------------
interface ppr_req_if import ppr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [CURSOR_W-1:0] play_cursor;
	logic                still_playing;

	modport source (output valid, req_type, play_cursor, still_playing, input ready);
	modport sink   (input valid, req_type, play_cursor, still_playing, output ready);
endinterface

/* rtl/ppr_rsp_if.sv */
// ----------------------------------------------------------------------------
// ppr_rsp_if: result channel
// Valid/ready channel carrying refill commands.
// ----------------------------------------------------------------------------
interface ppr_rsp_if import ppr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic              half_sel;
	logic [HEAD_W-1:0] blank_head;
	logic [TAIL_W-1:0] blank_tail;
	logic [OFS_W-1:0]  src_offset;
	logic [RS_W-1:0]   byte_count;
	logic              last;

	modport source (output valid, action, half_sel, blank_head, blank_tail, src_offset,
		byte_count, last, input ready);
	modport sink   (input valid, action, half_sel, blank_head, blank_tail, src_offset,
		byte_count, last, output ready);
endinterface

/* rtl/ppr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ppr_cfg_regs: configuration registers
// Write-only register file; ring size is clamped and made even on write.
// ----------------------------------------------------------------------------
module ppr_cfg_regs import ppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [RS_W-1:0]   ring_q;
	logic [OFS_W-1:0]  data_end_q;
	logic [DOFS_W-1:0] data_offset_q;

	function automatic logic [RS_W-1:0] clamp_ring(input logic [RS_W-1:0] v);
		logic [RS_W-1:0] r;
		r = v;
		if (r > RS_W'(MAX_RING_BYTES))
			r = RS_W'(MAX_RING_BYTES);
		if (r < RS_W'(MIN_RING_BYTES))
			r = RS_W'(MIN_RING_BYTES);
		return {r[RS_W-1:1], 1'b0};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q        <= clamp_ring(RST_RING_SIZE);
			data_end_q    <= RST_DATA_END;
			data_offset_q <= RST_DATA_OFFSET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RING_SIZE:   ring_q        <= clamp_ring(cfg_data[RS_W-1:0]);
				CFG_DATA_END:    data_end_q    <= cfg_data[OFS_W-1:0];
				CFG_DATA_OFFSET: data_offset_q <= cfg_data[DOFS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ring        = ring_q;
	assign cfg.data_end    = data_end_q;
	assign cfg.data_offset = data_offset_q;

endmodule

/* rtl/ppr_mod_pipe.sv */
// ----------------------------------------------------------------------------
// ppr_mod_pipe: cursor reduction pipeline
// Input register followed by restoring-remainder stages that reduce the
// play cursor modulo the ring size, a few compare/subtract steps per stage.
// ----------------------------------------------------------------------------
module ppr_mod_pipe import ppr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [RS_W-1:0] ring,
	ppr_req_if.sink         req,
	output logic            out_valid,
	input  logic            out_ready,
	output mod_item_t       out_item
);

	logic      vld_s [0:MOD_STAGES];
	mod_item_t itm_s [0:MOD_STAGES];
	logic      rdy   [0:MOD_STAGES];
	logic      src_v [0:MOD_STAGES];
	mod_item_t nxt   [0:MOD_STAGES];

	// Stage ready chain, back to front
	always_comb begin
		rdy[MOD_STAGES] = !vld_s[MOD_STAGES] || out_ready;
		for (int k = MOD_STAGES - 1; k >= 0; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_comb begin
		mod_item_t   t;
		logic [31:0] dv;
		int          sh;
		src_v[0]              = req.valid;
		nxt[0].req_type       = req.req_type;
		nxt[0].still_playing  = req.still_playing;
		nxt[0].play           = req.play_cursor;
		for (int k = 1; k <= MOD_STAGES; k++) begin
			src_v[k] = vld_s[k-1];
			t        = itm_s[k-1];
			for (int j = 0; j < MOD_STEPS; j++) begin
				sh = MOD_SHIFTS - 1 - ((k - 1) * MOD_STEPS + j);
				if (sh >= 0) begin
					dv = 32'(ring) << sh;
					if (32'(t.play) >= dv)
						t.play = t.play - dv[CURSOR_W-1:0];
				end
			end
			nxt[k] = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= MOD_STAGES; k++)
				vld_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k <= MOD_STAGES; k++)
				if (rdy[k])
					vld_s[k] <= src_v[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= MOD_STAGES; k++)
			if (rdy[k] && src_v[k])
				itm_s[k] <= nxt[k];
	end

	assign req.ready = rdy[0];
	assign out_valid = vld_s[MOD_STAGES];
	assign out_item  = itm_s[MOD_STAGES];

endmodule

/* rtl/ppr_ctrl.sv */
// ----------------------------------------------------------------------------
// ppr_ctrl: refill state and command generation
// Single-pass decision per request; up to three commands are loaded into a
// short result buffer that drains one transfer per cycle while rsp is ready.
// ----------------------------------------------------------------------------
module ppr_ctrl import ppr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      itm_valid,
	output logic      itm_ready,
	input  mod_item_t itm,
	ppr_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		MODE_STOPPED = 3'b001,
		MODE_ONESHOT = 3'b010,
		MODE_STREAM  = 3'b100
	} run_mode_t;

	// Halves still to be refilled before the drain phase
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_HALF1 = 2'd1;	// waiting to refill half 1
	localparam logic [1:0] PEND_HALF0 = 2'd2;	// waiting to refill half 0

	typedef struct packed {
		logic              go;
		logic [RS_W-1:0]   cnt;
		logic [OFS_W-1:0]  src;
		logic [MARK_W-1:0] nxt;
	} ra_t;

	run_mode_t           mode_q, nxt_mode;
	logic [1:0]          pend_q, nxt_pend;
	logic                drain_q, nxt_drain;
	logic [MARK_W-1:0]   wmark_q, nxt_wmark;
	logic [CURSOR_W-1:0] endc_q, nxt_endc;
	logic [MARK_W-1:0]   rmark_q, nxt_rmark;

	rsp_t                ent_q [0:2];
	logic [CNT_W-1:0]    cnt_q;
	rsp_t                res   [0:2];
	logic [CNT_W-1:0]    k;

	logic                take, free, fire;

	logic [RS_W-1:0]     rs;
	logic [HALF_W-1:0]   half;
	logic [EIGHTH_W-1:0] eighth;
	logic [OFS_W-1:0]    de;
	logic [DOFS_W-1:0]   dofs;

	logic                short_snd, empty_snd;
	logic [HEAD_W-1:0]   head;
	ra_t                 ra_start, ra_run;
	logic [MARK_W-1:0]   wm_nx, over;
	logic [HALF_W-1:0]   left;
	logic [17:0]         wrap_sum, played;
	logic                played_neg, gt8, lt8;

	function automatic ra_t read_ahead(input logic [MARK_W-1:0] rm,
		input logic [OFS_W-1:0] d_end, input logic [RS_W-1:0] ring);
		ra_t               r;
		logic [MARK_W-1:0] diff;
		r.go  = rm < {1'b0, d_end};
		diff  = {1'b0, d_end} - rm;
		r.cnt = (diff > MARK_W'(ring)) ? ring : diff[RS_W-1:0];
		r.src = rm[OFS_W-1:0];
		r.nxt = rm + MARK_W'(r.cnt);
		return r;
	endfunction

	function automatic rsp_t mk(input logic [ACT_W-1:0] act, input logic hs,
		input logic [HEAD_W-1:0] hd, input logic [TAIL_W-1:0] tl,
		input logic [OFS_W-1:0] src, input logic [RS_W-1:0] cnt);
		rsp_t r;
		r.action     = act;
		r.half_sel   = hs;
		r.blank_head = hd;
		r.blank_tail = tl;
		r.src_offset = src;
		r.byte_count = cnt;
		r.last       = 1'b0;
		return r;
	endfunction

	assign rs     = cfg.ring;
	assign half   = rs[RS_W-1:1];
	assign eighth = rs[RS_W-1:3];
	assign de     = cfg.data_end;
	assign dofs   = cfg.data_offset;

	// Start decisions
	assign short_snd = de < OFS_W'(rs);
	assign empty_snd = OFS_W'(dofs) >= de;
	assign head      = (dofs > half) ? half : dofs;
	assign ra_start  = read_ahead(MARK_W'(rs), de, rs);
	assign ra_run    = read_ahead(rmark_q, de, rs);

	// Tail blank for a half refill: bytes written past the data end
	assign wm_nx = wmark_q + MARK_W'(half);
	assign over  = (wm_nx > {1'b0, de}) ? (wm_nx - {1'b0, de}) : '0;
	assign left  = (over >= MARK_W'(half)) ? (half - HALF_W'(1)) : over[HALF_W-1:0];

	// Distance played since the end cursor, wrapping around the ring
	assign wrap_sum   = 18'(itm.play) + 18'(rs);
	assign played_neg = (itm.play < endc_q) && (wrap_sum < 18'(endc_q));
	assign played     = (itm.play >= endc_q) ? (18'(itm.play) - 18'(endc_q))
	                                         : (wrap_sum - 18'(endc_q));
	assign gt8 = played_neg || (played > 18'(eighth));
	assign lt8 = !played_neg && (played < 18'(eighth));

	always_comb begin
		nxt_mode  = mode_q;
		nxt_pend  = pend_q;
		nxt_drain = drain_q;
		nxt_wmark = wmark_q;
		nxt_endc  = endc_q;
		nxt_rmark = rmark_q;
		k         = '0;
		for (int i = 0; i < 3; i++)
			res[i] = '0;

		if (!itm.req_type) begin
			if (short_snd) begin
				if (empty_snd) begin
					res[0]   = mk(ACT_STOP, 1'b0, '0, '0, '0, '0);
					nxt_mode = MODE_STOPPED;
				end else begin
					res[0]   = mk(ACT_COPY_WHOLE, 1'b0, '0, '0, OFS_W'(dofs),
						RS_W'(de - OFS_W'(dofs)));
					nxt_mode = MODE_ONESHOT;
				end
				k = 2'd1;
			end else begin
				res[0] = mk(ACT_COPY_HALF, 1'b0, head, '0, '0, RS_W'(half));
				res[1] = mk(ACT_COPY_HALF, 1'b1, '0, '0, OFS_W'(half), RS_W'(half));
				k      = 2'd2;
				if (ra_start.go) begin
					res[2]    = mk(ACT_READ_AHEAD, 1'b0, '0, '0, ra_start.src, ra_start.cnt);
					k         = 2'd3;
					nxt_rmark = ra_start.nxt;
				end else begin
					nxt_rmark = MARK_W'(rs);
				end
				nxt_endc  = '0;
				nxt_pend  = PEND_HALF0;
				nxt_drain = 1'b0;
				nxt_wmark = MARK_W'(rs);
				nxt_mode  = MODE_STREAM;
			end
		end else begin
			case (mode_q)
				MODE_ONESHOT: begin
					if (!itm.still_playing) begin
						res[0]   = mk(ACT_STOP, 1'b0, '0, '0, '0, '0);
						k        = 2'd1;
						nxt_mode = MODE_STOPPED;
					end
				end
				MODE_STREAM: begin
					case (pend_q)
						PEND_NONE: begin
							if (!drain_q) begin
								if (gt8)
									nxt_drain = 1'b1;
							end else if (lt8) begin
								// data end reached: silence both halves and stop
								res[0]   = mk(ACT_COPY_HALF, 1'b0, half, '0, '0, RS_W'(half));
								res[1]   = mk(ACT_COPY_HALF, 1'b1, half, '0, OFS_W'(half),
									RS_W'(half));
								res[2]   = mk(ACT_STOP, 1'b0, '0, '0, '0, '0);
								k        = 2'd3;
								nxt_mode = MODE_STOPPED;
							end
						end
						PEND_HALF0: begin
							if (itm.play >= half) begin
								nxt_wmark = wm_nx;
								res[0]    = mk(ACT_COPY_HALF, 1'b0, '0, left[TAIL_W-1:0], '0,
									RS_W'(half));
								k         = 2'd1;
								if (left != '0) begin
									nxt_endc  = half - left;
									nxt_drain = 1'b0;
									nxt_pend  = PEND_NONE;
								end else begin
									nxt_pend  = PEND_HALF1;
								end
							end
						end
						PEND_HALF1: begin
							if (itm.play < half) begin
								nxt_wmark = wm_nx;
								res[0]    = mk(ACT_COPY_HALF, 1'b1, '0, left[TAIL_W-1:0],
									OFS_W'(half), RS_W'(half));
								k         = 2'd1;
								if (ra_run.go) begin
									res[1]    = mk(ACT_READ_AHEAD, 1'b0, '0, '0, ra_run.src,
										ra_run.cnt);
									k         = 2'd2;
									nxt_rmark = ra_run.nxt;
								end
								if (left != '0) begin
									nxt_endc  = CURSOR_W'(rs - RS_W'(left));
									nxt_drain = 1'b0;
									nxt_pend  = PEND_NONE;
								end else begin
									nxt_pend  = PEND_HALF0;
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		case (k)
			2'd1:    res[0].last = 1'b1;
			2'd2:    res[1].last = 1'b1;
			2'd3:    res[2].last = 1'b1;
			default: ;
		endcase
	end

	// Result buffer: loads a whole command set, shifts out one per transfer
	assign take      = rsp.valid && rsp.ready;
	assign free      = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && take);
	assign fire      = itm_valid && free;
	assign itm_ready = free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STOPPED;
			pend_q  <= PEND_NONE;
			drain_q <= 1'b0;
			wmark_q <= '0;
			endc_q  <= '0;
			rmark_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (fire) begin
				mode_q  <= nxt_mode;
				pend_q  <= nxt_pend;
				drain_q <= nxt_drain;
				wmark_q <= nxt_wmark;
				endc_q  <= nxt_endc;
				rmark_q <= nxt_rmark;
				cnt_q   <= k;
			end else if (take) begin
				cnt_q   <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ent_q[0] <= res[0];
			ent_q[1] <= res[1];
			ent_q[2] <= res[2];
		end else if (take) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	assign rsp.valid      = cnt_q != '0;
	assign rsp.action     = ent_q[0].action;
	assign rsp.half_sel   = ent_q[0].half_sel;
	assign rsp.blank_head = ent_q[0].blank_head;
	assign rsp.blank_tail = ent_q[0].blank_tail;
	assign rsp.src_offset = ent_q[0].src_offset;
	assign rsp.byte_count = ent_q[0].byte_count;
	assign rsp.last       = ent_q[0].last;

	// The final buffered command of a set carries last
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> ent_q[cnt_q - CNT_W'(1)].last)
		else $error("final buffered command lacks last");

	// Only the final command of a set carries last
	a_last_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CNT_W'(2)) |-> !ent_q[0].last)
		else $error("last set before end of command set");

	// No empty commands are ever presented
	a_no_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.action != ACT_NONE))
		else $error("command with no action presented");

	// Refill bookkeeping never reaches the unused pending code
	a_pend_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == PEND_NONE) || (pend_q == PEND_HALF1) || (pend_q == PEND_HALF0))
		else $error("pending halves code out of range");

endmodule

/* rtl/ping_pong_ring_refill_control.sv */
// ----------------------------------------------------------------------------
// ping_pong_ring_refill_control: two-half audio ring refill controller
// Primes the ring on start, refills each half as the play cursor leaves it,
// drains and silences the ring at the end of data, and stops one-shots.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                         done when
//   -------  ---  ----------------------------------------------  -----------------
//   req      in   req_type, play_cursor, still_playing            valid && ready
//   rsp      out  action, half_sel, blank_head, blank_tail,        valid && ready
//                 src_offset, byte_count, last
//   cfg      in   cfg_index, cfg_data                             cfg_we
//
// Path: a request passes the input register and three cursor-reduction
// stages of four compare/subtract steps each before the decision stage;
// its first command is presented in the cycle after the decision takes it.
// A request is taken every cycle while it causes at most one command and rsp
// is ready; after one that causes more, the next waits at the decision stage
// until the result buffer, moving one command per transfer, takes its last.
// Reset (arst_n low) stops the block, clears the refill state and empties all
// stages; configuration returns to ring 65536, data end 0, data offset 44.
// Stalls on rsp back up through the result buffer and the reduction stages;
// req.ready drops only once every stage holds a request.
// ----------------------------------------------------------------------------
module ping_pong_ring_refill_control import ppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ppr_req_if.sink               req,
	ppr_rsp_if.source             rsp
);

	cfg_t      cfg;
	logic      itm_valid;
	logic      itm_ready;
	mod_item_t itm;

	// Register file; ring size is held already clamped to the legal range
	ppr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Play cursor reduced modulo the ring size ahead of the decision stage
	ppr_mod_pipe u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.ring      (cfg.ring),
		.req       (req),
		.out_valid (itm_valid),
		.out_ready (itm_ready),
		.out_item  (itm)
	);

	// Refill state, command generation and result buffer
	ppr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.itm_valid (itm_valid),
		.itm_ready (itm_ready),
		.itm       (itm),
		.rsp       (rsp)
	);

endmodule

/* sim/ppr_refill_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_refill_checker: refill command predictor and scoreboard
// Mirrors register writes and request transfers, works out the refill commands
// each request should cause and compares them with the result channel.
// ----------------------------------------------------------------------------
module ppr_refill_checker import ppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ppr_req_if                    req,
	ppr_rsp_if                    rsp,
	output int                    mismatches,
	output int                    outstanding
);

	localparam logic REQ_START = 1'b0;
	localparam int   SHOWN_MISMATCHES = 10;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_ONESHOT = 2'd1,
		MODE_STREAM  = 2'd2
	} play_mode_t;

	// register copies
	logic [RS_W-1:0]     ring_size_q;
	logic [OFS_W-1:0]    data_end_q;
	logic [DOFS_W-1:0]   data_offset_q;

	// refill state
	play_mode_t          mode_q;
	logic [1:0]          halves_due;
	logic                drain_armed;
	logic [MARK_W-1:0]   write_mark;
	logic [CURSOR_W-1:0] end_cursor;
	logic [MARK_W-1:0]   read_mark;

	rsp_t expected_cmds[$];
	int   cmds_this_item;

	function automatic logic [RS_W-1:0] ring_bytes();
		logic [RS_W-1:0] rs;
		rs = ring_size_q;
		if (rs > RS_W'(MAX_RING_BYTES))
			rs = RS_W'(MAX_RING_BYTES);
		if (rs < RS_W'(MIN_RING_BYTES))
			rs = RS_W'(MIN_RING_BYTES);
		rs[0] = 1'b0;
		return rs;
	endfunction

	// bytes written past the data end, kept below one half
	function automatic logic [TAIL_W-1:0] tail_overrun(input logic [HALF_W-1:0] half);
		logic [MARK_W-1:0] left;
		left = '0;
		if (write_mark > {1'b0, data_end_q})
			left = write_mark - {1'b0, data_end_q};
		if (left >= MARK_W'(half))
			left = MARK_W'(half) - 1'b1;
		return left[TAIL_W-1:0];
	endfunction

	function automatic string describe(input rsp_t c);
		return $sformatf("act %0d half %0d head %0d tail %0d src 0x%08h count %0d last %0d",
			c.action, c.half_sel, c.blank_head, c.blank_tail, c.src_offset,
			c.byte_count, c.last);
	endfunction

	task automatic push_cmd(input logic [ACT_W-1:0] act, input logic hs,
		input logic [HEAD_W-1:0] head, input logic [TAIL_W-1:0] tail,
		input logic [OFS_W-1:0] src, input logic [RS_W-1:0] cnt);
		rsp_t c;
		c.action     = act;
		c.half_sel   = hs;
		c.blank_head = head;
		c.blank_tail = tail;
		c.src_offset = src;
		c.byte_count = cnt;
		c.last       = 1'b0;
		expected_cmds.push_back(c);
		cmds_this_item++;
	endtask

	task automatic issue_read_ahead(input logic [RS_W-1:0] rs);
		logic [MARK_W-1:0] cnt;
		if (read_mark < {1'b0, data_end_q}) begin
			cnt = {1'b0, data_end_q} - read_mark;
			if (cnt > MARK_W'(rs))
				cnt = MARK_W'(rs);
			push_cmd(ACT_READ_AHEAD, 1'b0, '0, '0, read_mark[OFS_W-1:0], cnt[RS_W-1:0]);
			read_mark = read_mark + cnt;
		end
	endtask

	task automatic predict_refill(input logic kind, input logic [CURSOR_W-1:0] cursor,
		input logic playing);
		logic [RS_W-1:0]     rs;
		logic [HALF_W-1:0]   half;
		logic [EIGHTH_W-1:0] eighth;
		logic [CURSOR_W-1:0] play;
		logic [63:0]         played;
		logic [HEAD_W-1:0]   head;
		logic [TAIL_W-1:0]   left;
		rsp_t                final_cmd;
		rs     = ring_bytes();
		half   = rs[RS_W-1:1];
		eighth = rs[RS_W-1:3];
		cmds_this_item = 0;
		if (kind == REQ_START) begin
			if (data_end_q < OFS_W'(rs)) begin
				// short sound: one whole copy, or nothing to play at all
				if (OFS_W'(data_offset_q) >= data_end_q) begin
					push_cmd(ACT_STOP, 1'b0, '0, '0, '0, '0);
					mode_q = MODE_STOPPED;
				end else begin
					push_cmd(ACT_COPY_WHOLE, 1'b0, '0, '0, OFS_W'(data_offset_q),
						RS_W'(data_end_q - OFS_W'(data_offset_q)));
					mode_q = MODE_ONESHOT;
				end
			end else begin
				head = (data_offset_q > half) ? half : data_offset_q;
				push_cmd(ACT_COPY_HALF, 1'b0, head, '0, '0, RS_W'(half));
				push_cmd(ACT_COPY_HALF, 1'b1, '0, '0, OFS_W'(half), RS_W'(half));
				read_mark = MARK_W'(rs);
				issue_read_ahead(rs);
				end_cursor  = '0;
				halves_due  = 2'd2;
				drain_armed = 1'b0;
				write_mark  = MARK_W'(rs);
				mode_q      = MODE_STREAM;
			end
		end else if (mode_q == MODE_ONESHOT) begin
			if (!playing) begin
				push_cmd(ACT_STOP, 1'b0, '0, '0, '0, '0);
				mode_q = MODE_STOPPED;
			end
		end else if (mode_q == MODE_STREAM) begin
			play = CURSOR_W'(cursor % rs);
			if (halves_due == 2'd0) begin
				// drain: arm once the cursor moves away, fire when it comes back
				if (play >= end_cursor)
					played = 64'(play) - 64'(end_cursor);
				else
					played = 64'(play) + 64'(rs) - 64'(end_cursor);
				if (!drain_armed) begin
					if (played > 64'(eighth))
						drain_armed = 1'b1;
				end else if (played < 64'(eighth)) begin
					push_cmd(ACT_COPY_HALF, 1'b0, half, '0, '0, RS_W'(half));
					push_cmd(ACT_COPY_HALF, 1'b1, half, '0, OFS_W'(half), RS_W'(half));
					push_cmd(ACT_STOP, 1'b0, '0, '0, '0, '0);
					mode_q = MODE_STOPPED;
				end
			end else if (halves_due == 2'd2 && play >= half) begin
				write_mark = write_mark + MARK_W'(half);
				left = tail_overrun(half);
				push_cmd(ACT_COPY_HALF, 1'b0, '0, left, '0, RS_W'(half));
				if (left != '0) begin
					end_cursor  = half - HALF_W'(left);
					drain_armed = 1'b0;
					halves_due  = 2'd0;
				end else begin
					halves_due = 2'd1;
				end
			end else if (halves_due == 2'd1 && play < half) begin
				write_mark = write_mark + MARK_W'(half);
				left = tail_overrun(half);
				push_cmd(ACT_COPY_HALF, 1'b1, '0, left, OFS_W'(half), RS_W'(half));
				issue_read_ahead(rs);
				if (left != '0) begin
					end_cursor  = CURSOR_W'(rs - RS_W'(left));
					drain_armed = 1'b0;
					halves_due  = 2'd0;
				end else begin
					halves_due = 2'd2;
				end
			end
		end
		if (cmds_this_item > 0) begin
			final_cmd = expected_cmds[expected_cmds.size() - 1];
			final_cmd.last = 1'b1;
			expected_cmds[expected_cmds.size() - 1] = final_cmd;
		end
	endtask

	task automatic check_cmd();
		rsp_t got;
		rsp_t want;
		got.action     = rsp.action;
		got.half_sel   = rsp.half_sel;
		got.blank_head = rsp.blank_head;
		got.blank_tail = rsp.blank_tail;
		got.src_offset = rsp.src_offset;
		got.byte_count = rsp.byte_count;
		got.last       = rsp.last;
		if (expected_cmds.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("%0t: command with none expected: %s", $time, describe(got));
		end else begin
			want = expected_cmds.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES) begin
					$display("%0t: command mismatch", $time);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q   = RST_RING_SIZE;
			data_end_q    = RST_DATA_END;
			data_offset_q = RST_DATA_OFFSET;
			mode_q        = MODE_STOPPED;
			halves_due    = 2'd0;
			drain_armed   = 1'b0;
			write_mark    = '0;
			end_cursor    = '0;
			read_mark     = '0;
			mismatches    = 0;
			expected_cmds.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RING_SIZE:   ring_size_q   = cfg_data[RS_W-1:0];
					CFG_DATA_END:    data_end_q    = cfg_data[OFS_W-1:0];
					CFG_DATA_OFFSET: data_offset_q = cfg_data[DOFS_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready)
				check_cmd();
			if (req.valid && req.ready)
				predict_refill(req.req_type, req.play_cursor, req.still_playing);
		end
		outstanding = expected_cmds.size();
	end

endmodule

/* sim/ping_pong_ring_refill_control_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_pong_ring_refill_control_test: testbench top for the ring refill control
// Directed start/poll sequences on corner settings, then random phases of
// streaming, one-shot and noise traffic under sender and receiver stalls.
// ----------------------------------------------------------------------------
module ping_pong_ring_refill_control_test;
	import ppr_pkg::*;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_POLL  = 1'b1;

	localparam int TOTAL_ITEMS    = 300;
	localparam int STALL_LIMIT    = 3000;	// cycles with no transfer and no write
	localparam int SETTLE_CYCLES  = 12;	// reduction stages, decision, three commands
	localparam int HOLDOFF_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppr_req_if req_ch();
	ppr_rsp_if rsp_ch();

	int mismatches;
	int outstanding;
	int tx_idle_pct;
	int rx_idle_pct;
	int holdoff_asked;	// bumped by the stimulus, served by the result sink
	int items_sent;
	int stall_cycles;

	ping_pong_ring_refill_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	ppr_refill_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Result sink: random ready at the falling edge, or a long hold-off when
	// the stimulus asks for one so the pipeline backs up into the request side.
	initial begin : result_sink
		int holdoff_seen;
		int holdoff_left;
		holdoff_seen = 0;
		holdoff_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_asked != holdoff_seen) begin
				holdoff_seen = holdoff_asked;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: a correct run never goes this long without any transfer or register write.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One request transfer. Entered and left at a falling edge; valid stays
	// high across back-to-back requests.
	task automatic send_item(input logic kind, input logic [CURSOR_W-1:0] cursor,
		input logic playing);
		// stall mix: receiver-heavy idling, then sender-heavy, then none
		if (items_sent < 110) begin
			tx_idle_pct = 30;
			rx_idle_pct = 61;
		end else if (items_sent < 220) begin
			tx_idle_pct = 61;
			rx_idle_pct = 30;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid         = 1'b1;
		req_ch.req_type      = kind;
		req_ch.play_cursor   = cursor;
		req_ch.still_playing = playing;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Stop offering, wait for every expected command, then let any request that
	// causes no command clear the pipeline.
	task automatic settle();
		req_ch.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Start, then a play cursor walking forward around the ring. A few polls
	// are noise (random cursor, or a restart in the middle of the sound).
	task automatic stream_session(input int polls, input int rs);
		int cur;
		int step;
		int wraps;
		cur = 0;
		send_item(REQ_START, CURSOR_W'($urandom), 1'($urandom_range(1)));
		repeat (polls) begin
			if ($urandom_range(99) < 6) begin
				send_item(1'($urandom_range(1)), CURSOR_W'($urandom), 1'($urandom_range(1)));
			end else begin
				step = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, rs / 3);
				cur = (cur + step) % rs;
				// cursor past the ring end, same position modulo the ring
				wraps = ($urandom_range(99) < 20) ? $urandom_range(0, (65535 - cur) / rs) : 0;
				send_item(REQ_POLL, CURSOR_W'(cur + wraps * rs), 1'($urandom_range(1)));
			end
		end
	endtask

	// Start a short sound, poll while it plays, then report it finished.
	task automatic oneshot_session();
		send_item(REQ_START, CURSOR_W'($urandom), 1'($urandom_range(1)));
		repeat ($urandom_range(0, 4)) send_item(REQ_POLL, CURSOR_W'($urandom), 1'b1);
		send_item(REQ_POLL, CURSOR_W'($urandom), 1'b0);
		if ($urandom_range(1))
			send_item(REQ_POLL, CURSOR_W'($urandom), 1'($urandom_range(1)));
	endtask

	// New settings, then a burst of traffic that suits them.
	task automatic run_random_phase();
		int                pick;
		int                rs;
		int                sound;
		int                phase_end;
		logic [RS_W-1:0]   raw_ring;
		logic [OFS_W-1:0]  dend;
		logic [DOFS_W-1:0] dofs;
		// mostly small rings so refills and drains come quickly
		pick = $urandom_range(99);
		if (pick < 50)
			rs = MIN_RING_BYTES + 2 * $urandom_range(0, 56);
		else if (pick < 75)
			rs = 2 * $urandom_range(64, 2048);
		else if (pick < 90)
			rs = MAX_RING_BYTES;
		else
			rs = MIN_RING_BYTES;
		// sometimes a raw value the block has to clamp or round down
		raw_ring = RS_W'(rs);
		if ($urandom_range(1)) begin
			if (rs == MIN_RING_BYTES)
				raw_ring = RS_W'($urandom_range(0, 17));
			else if (rs == MAX_RING_BYTES)
				raw_ring = RS_W'($urandom_range(65536, 131071));
			else
				raw_ring = RS_W'(rs + 1);
		end
		sound = $urandom_range(99);
		if (sound < 70) begin
			// streaming sound, usually ending within a few halves
			pick = $urandom_range(99);
			if (pick < 50)
				dend = OFS_W'(rs + $urandom_range(0, rs));
			else if (pick < 85)
				dend = OFS_W'(rs + $urandom_range(0, 3 * rs));
			else
				dend = OFS_W'($urandom);
			if (dend < OFS_W'(rs))
				dend = OFS_W'(rs);
		end else if (sound < 90) begin
			dend = OFS_W'($urandom_range(0, rs - 1));
		end else begin
			dend = OFS_W'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 60)
			dofs = DOFS_W'($urandom_range(0, 64));
		else if (pick < 85)
			dofs = DOFS_W'($urandom_range(0, rs));
		else if (pick < 95)
			dofs = '1;
		else
			dofs = DOFS_W'($urandom);
		settle();
		write_reg(CFG_RING_SIZE, CFG_DATA_W'(raw_ring));
		write_reg(CFG_DATA_END, dend);
		write_reg(CFG_DATA_OFFSET, CFG_DATA_W'(dofs));
		phase_end = items_sent + $urandom_range(25, 45);
		while (items_sent < phase_end) begin
			if (sound < 70)
				stream_session($urandom_range(10, 40), rs);
			else if (sound < 90)
				oneshot_session();
			else
				send_item(1'($urandom_range(1)), CURSOR_W'($urandom), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		cfg_we               = 1'b0;
		cfg_index            = CFG_RING_SIZE;
		cfg_data             = '0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_START;
		req_ch.play_cursor   = '0;
		req_ch.still_playing = 1'b0;
		tx_idle_pct          = 30;
		rx_idle_pct          = 61;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Settings after reset: data end 0 is an empty sound, so start just stops;
		// a poll while stopped does nothing.
		send_item(REQ_START, 16'h0000, 1'b0);
		send_item(REQ_POLL, 16'hFFFF, 1'b1);

		// One-shot: ring 5 is raised to the minimum, whole copy from the
		// header offset, stop once the player reports done, then a stopped poll.
		settle();
		write_reg(CFG_RING_SIZE, 32'd5);
		write_reg(CFG_DATA_END, 32'd10);
		write_reg(CFG_DATA_OFFSET, 32'd2);
		send_item(REQ_START, 16'h0000, 1'b1);
		send_item(REQ_POLL, 16'h0000, 1'b1);
		send_item(REQ_POLL, 16'h0000, 1'b0);
		send_item(REQ_POLL, 16'h8000, 1'b0);

		// Minimum ring, sound of exactly one ring, header blank saturated to a
		// half. Cursor beyond the ring refills half 0 with the tail blanked,
		// then the cursor moves away and back to drain and stop.
		settle();
		write_reg(CFG_RING_SIZE, 32'd0);
		write_reg(CFG_DATA_END, 32'd16);
		write_reg(CFG_DATA_OFFSET, 32'h0000_FFFF);
		send_item(REQ_START, 16'h0000, 1'b0);
		send_item(REQ_POLL, 16'hFFFF, 1'b1);
		send_item(REQ_POLL, 16'd3, 1'b1);
		send_item(REQ_POLL, 16'd6, 1'b0);
		send_item(REQ_POLL, 16'd2, 1'b1);

		// Oversized ring clamps to the maximum, longest data end: full reads ahead
		// at start and on the half-1 refill, and a restart in the middle of streaming.
		settle();
		write_reg(CFG_RING_SIZE, 32'h0001_FFFF);
		write_reg(CFG_DATA_END, 32'hFFFF_FFFF);
		write_reg(CFG_DATA_OFFSET, 32'd0);
		send_item(REQ_START, 16'hFFFF, 1'b1);
		send_item(REQ_POLL, 16'd32768, 1'b1);
		send_item(REQ_POLL, 16'd0, 1'b0);
		send_item(REQ_START, 16'h5555, 1'b0);
		send_item(REQ_POLL, 16'd40000, 1'b1);

		// Short sound whose header reaches the data end: nothing to play.
		settle();
		write_reg(CFG_RING_SIZE, 32'd101);
		write_reg(CFG_DATA_END, 32'd50);
		write_reg(CFG_DATA_OFFSET, 32'd50);
		send_item(REQ_START, 16'hAAAA, 1'b1);

		// Random phases. Each phase change pauses the sender until every command
		// has come back; two of them also start a long receiver hold-off.
		while (items_sent < TOTAL_ITEMS) begin
			if ((holdoff_asked == 0 && items_sent >= 140)
				|| (holdoff_asked == 1 && items_sent >= 240)) begin
				// drain first so the hold-off lands on fresh traffic
				settle();
				holdoff_asked++;
			end
			run_random_phase();
		end

		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/ppr_pkg.sv
rtl/ppr_req_if.sv
rtl/ppr_rsp_if.sv
rtl/ppr_cfg_regs.sv
rtl/ppr_mod_pipe.sv
rtl/ppr_ctrl.sv
rtl/ping_pong_ring_refill_control.sv
sim/ppr_refill_checker.sv
sim/ping_pong_ring_refill_control_test.sv
